>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file of the rolling window block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a rising clock edge, disabled while reset is low.
`define RWS_ASSERT_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, with the common failure message.
`define RWS_ASSERT(label, clk, rst_n, prop) \
  `RWS_ASSERT_MSG(label, clk, rst_n, prop, "rolling window statistics check failed")

`endif

>>> rtl/core/rws_pkg.sv
// Package of the rolling window statistics block: widths, codes and defaults.
// No dependencies; all files of the block but rws_ram and the assertion macros use it.
`timescale 1ns / 1ps
`default_nettype none

package rws_pkg;

  // Default ring depth (largest usable window).
  localparam int unsigned WINDOW_MAX = 1024;

  // Field widths of the channels.
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned WIN_W      = 11;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STAT_W     = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  // Running sums and squares.
  localparam int unsigned SUM_W   = 35;
  localparam int unsigned SQSUM_W = 58;
  localparam int unsigned SQ_W    = 2 * SAMPLE_W;

  // Serial arithmetic units.
  localparam int unsigned MUL_A_W   = SQSUM_W;
  localparam int unsigned MUL_B_W   = SUM_W;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_NUM_W = 77;
  localparam int unsigned DIV_DEN_W = 42;
  localparam int unsigned ROOT_IN_W = 63;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned STD_W     = 31;

  // Fixed-point scalings.
  localparam int unsigned MEAN_SHIFT = 4;
  localparam int unsigned VAR_SHIFT  = 8;
  localparam int unsigned Z_SHIFT    = 20;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 1'b0,
    CFG_STAT_MODE     = 1'b1
  } cfg_idx_e;

  // Statistic selection codes; the unused code acts as the mean.
  localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ZSCORE = 2'd2;

  // Register reset values.
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 11'd20;
  localparam logic [MODE_W-1:0] MODE_RESET   = MODE_MEAN;

endpackage

`default_nettype wire

>>> rtl/core/rws_if.sv
// Channel interfaces of the rolling window block: samples, results, config writes.
// Depends on rws_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

// Sample channel.
interface rws_in_if;
  import rws_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       series_start;
  modport source (output valid, sample, series_start, input ready);
  modport sink   (input valid, sample, series_start, output ready);
endinterface

// Result channel.
interface rws_out_if;
  import rws_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [STAT_W-1:0] stat_value;
  logic                     window_full;
  logic                     bad_config;
  modport source (output valid, stat_value, window_full, bad_config, input ready);
  modport sink   (input valid, stat_value, window_full, bad_config, output ready);
endinterface

// Configuration write channel.
interface rws_cfg_if;
  import rws_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rolling_window_statistics.sv
// Rolling window mean, sample standard deviation and z-score over Q12.12 samples.
// Uses rws_pkg, rws_if, rws_ram, rws_mul, rws_div and rws_sqrt.
// One item at a time. A filling window or a flagged configuration skips the serial units; the mean
// takes one division, the deviation two multiplications, a division and a root, and the z-score
// one more division (a flat window skips that root and division). Ready returns with the result.
// Reset zeroes sums, count, pointer and valid, loads config defaults; ring contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module rolling_window_statistics #(
  parameter int unsigned WindowMax = rws_pkg::WINDOW_MAX
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rws_in_if.sink    smp_i,
  rws_out_if.source res_o,
  rws_cfg_if.sink   cfg_i
);
  import rws_pkg::*;

  localparam int unsigned PtrW = $clog2(WindowMax);
  localparam int unsigned WxW  = WIN_W + 1 + SAMPLE_W;
  localparam int unsigned TW   = WxW + 1;
  localparam int unsigned Ww1W = 2 * WIN_W;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_UPD  = 4'd2;
  localparam logic [3:0] ST_SEL  = 4'd3;
  localparam logic [3:0] ST_MQ   = 4'd4;
  localparam logic [3:0] ST_MS   = 4'd5;
  localparam logic [3:0] ST_DV   = 4'd6;
  localparam logic [3:0] ST_SQ   = 4'd7;
  localparam logic [3:0] ST_STD  = 4'd8;
  localparam logic [3:0] ST_ZD   = 4'd9;
  localparam logic [3:0] ST_MEAN = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  // Control state.
  logic [3:0]                state_q, state_d;
  logic [WIN_W-1:0]          win_q, win_d;
  logic [MODE_W-1:0]         mode_q, mode_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [SQSUM_W-1:0]        sqs_q, sqs_d;
  logic [WIN_W-1:0]          seen_q, seen_d;
  logic [PtrW-1:0]           ptr_q, ptr_d;
  logic                      out_vld_q, out_vld_d;

  // Payload registers.
  logic signed [SAMPLE_W-1:0] x_q;
  logic [WIN_W-1:0]           w_q;
  logic                       rm_q;
  logic signed [SAMPLE_W-1:0] ov_q;
  logic [SQ_W-1:0]            ovv_q;
  logic [SQ_W-1:0]            xx_q;
  logic signed [WxW-1:0]      wx_q;
  logic [Ww1W-1:0]            ww1_q;
  logic                       full_q;
  logic                       bad_q;
  logic [MUL_P_W-1:0]         wq_q;
  logic [STD_W-1:0]           s_q;
  logic                       tneg_q;
  logic signed [STAT_W-1:0]   res_q;
  logic signed [STAT_W-1:0]   out_stat_q;
  logic                       out_full_q;
  logic                       out_bad_q;

  // Datapath nets.
  logic                       in_take;
  logic                       out_free;
  logic [WIN_W-1:0]           w_eff;
  logic [PtrW-1:0]            ptr_cur;
  logic [WIN_W-1:0]           seen_cur;
  logic [PtrW+1:0]            idx_diff;
  logic [PtrW+1:0]            idx_wrap;
  logic [PtrW-1:0]            rd_idx;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] old_x;
  logic signed [SQ_W-1:0]     old_sq;
  logic signed [SQ_W-1:0]     new_sq;
  logic [WIN_W-1:0]           seen_new;
  logic [SUM_W-1:0]           sum_mag;
  logic signed [TW-1:0]       t_dev;
  logic [TW-1:0]              t_mag;
  logic [STD_W-1:0]           s_one;
  logic [MUL_P_W-1:0]         var_num;
  logic                       var_pos;
  logic [STAT_W-1:0]          mean_mag;
  logic [STAT_W-1:0]          z_val;

  // Unit interfaces.
  logic                 mul_start;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic                 mul_done;
  logic [MUL_P_W-1:0]   mul_prod;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;
  logic [DIV_DEN_W-1:0] div_rem;
  logic                 sqrt_start;
  logic [ROOT_IN_W-1:0] sqrt_val;
  logic                 sqrt_done;
  logic [ROOT_W-1:0]    sqrt_root;

  assign smp_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_take     = smp_i.valid && (state_q == ST_IDLE);
  assign out_free    = !out_vld_q || res_o.ready;

  // Effective window: zero acts as one, and it never exceeds the ring.
  always_comb begin
    w_eff = win_q;
    if (win_q == '0) begin
      w_eff = WIN_W'(1);
    end else if (32'(win_q) > WindowMax) begin
      w_eff = WIN_W'(WindowMax);
    end
  end

  // A series start resets count and pointer before the oldest entry is located.
  assign ptr_cur  = smp_i.series_start ? '0 : ptr_q;
  assign seen_cur = smp_i.series_start ? '0 : seen_q;
  assign idx_diff = {2'b00, ptr_cur} - (PtrW + 2)'(w_eff);
  assign idx_wrap = idx_diff[PtrW+1] ? idx_diff + (PtrW + 2)'(WindowMax) : idx_diff;
  assign rd_idx   = idx_wrap[PtrW-1:0];

  // Sample ring.
  rws_ram #(
    .Width (SAMPLE_W),
    .Depth (WindowMax)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_UPD),
    .waddr_i (ptr_q),
    .wdata_i (x_q),
    .re_i    (in_take),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  assign old_x    = $signed(ram_rdata);
  assign old_sq   = old_x * old_x;
  assign new_sq   = x_q * x_q;
  assign seen_new = rm_q ? seen_q : seen_q + 1'b1;
  assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  // Deviation of the newest sample, scaled by the window.
  assign t_dev = TW'(wx_q) - TW'(sum_q);
  assign t_mag = t_dev[TW-1] ? TW'(-t_dev) : TW'(t_dev);
  assign s_one = (s_q == '0) ? STD_W'(1) : s_q;

  // Scaled spread W*Q - S*S, positive only when the window varies.
  assign var_num = wq_q - mul_prod;
  assign var_pos = wq_q > mul_prod;

  // Mean rounds toward minus infinity.
  assign mean_mag = div_quot[STAT_W-1:0]
                  + STAT_W'(sum_q[SUM_W-1] && (div_rem != '0));

  // Saturated z-score from the quotient magnitude.
  always_comb begin
    if (tneg_q) begin
      z_val = (div_quot > DIV_NUM_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                             : -div_quot[STAT_W-1:0];
    end else begin
      z_val = (div_quot > DIV_NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                      : div_quot[STAT_W-1:0];
    end
  end

  // Operands for the serial units, launched on the state transitions.
  always_comb begin
    mul_start  = 1'b0;
    mul_a      = MUL_A_W'(sqs_q);
    mul_b      = MUL_B_W'(w_q);
    div_start  = 1'b0;
    div_num    = DIV_NUM_W'({sum_mag, MEAN_SHIFT'(0)});
    div_den    = DIV_DEN_W'(w_q);
    sqrt_start = 1'b0;
    sqrt_val   = div_quot[ROOT_IN_W-1:0];
    case (state_q)
      ST_SEL: begin
        if (full_q && !bad_q) begin
          if ((mode_q == MODE_STD) || (mode_q == MODE_ZSCORE)) begin
            mul_start = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_MQ: begin
        mul_a     = MUL_A_W'(sum_mag);
        mul_b     = MUL_B_W'(sum_mag);
        mul_start = mul_done;
      end
      ST_MS: begin
        div_num   = DIV_NUM_W'({var_num, VAR_SHIFT'(0)});
        div_den   = DIV_DEN_W'(ww1_q);
        div_start = mul_done && var_pos;
      end
      ST_DV: begin
        sqrt_start = div_done && (div_quot[DIV_NUM_W-1:ROOT_IN_W] == '0);
      end
      ST_STD: begin
        div_num   = DIV_NUM_W'({t_mag, Z_SHIFT'(0)});
        div_den   = DIV_DEN_W'(w_q) * DIV_DEN_W'(s_one);
        div_start = (mode_q == MODE_ZSCORE);
      end
      default: begin
      end
    endcase
  end

  // Sequencer, running sums and configuration registers.
  always_comb begin
    state_d   = state_q;
    win_d     = win_q;
    mode_d    = mode_q;
    sum_d     = sum_q;
    sqs_d     = sqs_q;
    seen_d    = seen_q;
    ptr_d     = ptr_q;
    out_vld_d = out_vld_q;

    if (out_vld_q && res_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if (smp_i.series_start) begin
            sum_d  = '0;
            sqs_d  = '0;
            seen_d = '0;
            ptr_d  = '0;
          end
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        sum_d  = sum_q + SUM_W'(x_q) - (rm_q ? SUM_W'(ov_q) : '0);
        sqs_d  = sqs_q + SQSUM_W'(xx_q) - (rm_q ? SQSUM_W'(ovv_q) : '0);
        seen_d = seen_new;
        ptr_d  = (ptr_q == PtrW'(WindowMax - 1)) ? '0 : ptr_q + 1'b1;
        state_d = ST_SEL;
      end
      ST_SEL: begin
        if (!full_q || bad_q) begin
          state_d = ST_DONE;
        end else if ((mode_q == MODE_STD) || (mode_q == MODE_ZSCORE)) begin
          state_d = ST_MQ;
        end else begin
          state_d = ST_MEAN;
        end
      end
      ST_MQ: begin
        if (mul_done) begin
          state_d = ST_MS;
        end
      end
      ST_MS: begin
        if (mul_done) begin
          state_d = var_pos ? ST_DV : ST_STD;
        end
      end
      ST_DV: begin
        if (div_done) begin
          state_d = sqrt_start ? ST_SQ : ST_STD;
        end
      end
      ST_SQ: begin
        if (sqrt_done) begin
          state_d = ST_STD;
        end
      end
      ST_STD: begin
        state_d = (mode_q == MODE_ZSCORE) ? ST_ZD : ST_DONE;
      end
      ST_ZD: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Configuration transactions; a window write opens a new series.
    if (cfg_i.valid) begin
      if (cfg_i.index == CFG_WINDOW_LENGTH) begin
        win_d  = cfg_i.data[WIN_W-1:0];
        sum_d  = '0;
        sqs_d  = '0;
        seen_d = '0;
        ptr_d  = '0;
      end else if (cfg_i.index == CFG_STAT_MODE) begin
        mode_d = cfg_i.data[MODE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      win_q     <= WINDOW_RESET;
      mode_q    <= MODE_RESET;
      sum_q     <= '0;
      sqs_q     <= '0;
      seen_q    <= '0;
      ptr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      win_q     <= win_d;
      mode_q    <= mode_d;
      sum_q     <= sum_d;
      sqs_q     <= sqs_d;
      seen_q    <= seen_d;
      ptr_q     <= ptr_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers along the item's way through the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          x_q  <= smp_i.sample;
          w_q  <= w_eff;
          rm_q <= seen_cur >= w_eff;
        end
      end
      ST_RD: begin
        ov_q  <= old_x;
        ovv_q <= SQ_W'(old_sq);
        xx_q  <= SQ_W'(new_sq);
        wx_q  <= $signed({1'b0, w_q}) * x_q;
        ww1_q <= Ww1W'(w_q) * Ww1W'(w_q - 1'b1);
      end
      ST_UPD: begin
        full_q <= seen_new >= w_q;
        bad_q  <= ((mode_q == MODE_STD) || (mode_q == MODE_ZSCORE)) && (w_q < WIN_W'(2));
        res_q  <= '0;
      end
      ST_MQ: begin
        if (mul_done) begin
          wq_q <= mul_prod;
        end
      end
      ST_MS: begin
        if (mul_done && !var_pos) begin
          s_q <= '0;
        end
      end
      ST_DV: begin
        if (div_done && !sqrt_start) begin
          s_q <= STD_W'(32'h7FFF_FFFF);
        end
      end
      ST_SQ: begin
        if (sqrt_done) begin
          s_q <= sqrt_root[ROOT_W-1] ? STD_W'(32'h7FFF_FFFF) : sqrt_root[STD_W-1:0];
        end
      end
      ST_STD: begin
        tneg_q <= t_dev[TW-1];
        res_q  <= $signed({1'b0, s_q});
      end
      ST_ZD: begin
        if (div_done) begin
          res_q <= $signed(z_val);
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          res_q <= sum_q[SUM_W-1] ? $signed(-mean_mag) : $signed(mean_mag);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_stat_q <= res_q;
          out_full_q <= full_q;
          out_bad_q  <= bad_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Serial arithmetic units.
  rws_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  rws_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  rws_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sqrt_val),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // Result register.
  assign res_o.valid       = out_vld_q;
  assign res_o.stat_value  = out_stat_q;
  assign res_o.window_full = out_full_q;
  assign res_o.bad_config  = out_bad_q;

endmodule

`default_nettype wire

>>> rtl/core/rws_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rws_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/rws_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, stops early on zero.
// Depends on rws_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module rws_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rws_pkg::MUL_A_W-1:0]   a_i,
  input  logic [rws_pkg::MUL_B_W-1:0]   b_i,
  output logic                          done_o,
  output logic [rws_pkg::MUL_P_W-1:0]   prod_o
);
  import rws_pkg::*;

  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [MUL_P_W-1:0] a_q, a_d;
  logic [MUL_B_W-1:0] b_q, b_d;
  logic [MUL_P_W-1:0] acc_q, acc_d;

  // One partial product per cycle while multiplier bits remain.
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      run_d = 1'b1;
      a_d   = MUL_P_W'(a_i);
      b_d   = b_i;
      acc_d = '0;
    end else if (run_q) begin
      if (b_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        if (b_q[0]) begin
          acc_d = acc_q + a_q;
        end
        a_d = {a_q[MUL_P_W-2:0], 1'b0};
        b_d = {1'b0, b_q[MUL_B_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

>>> rtl/core/rws_div.sv
// Restoring divider, one quotient bit per cycle, with remainder.
// Depends on rws_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module rws_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rws_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [rws_pkg::DIV_DEN_W-1:0]   den_i,
  output logic                            done_o,
  output logic [rws_pkg::DIV_NUM_W-1:0]   quot_o,
  output logic [rws_pkg::DIV_DEN_W-1:0]   rem_o
);
  import rws_pkg::*;

  localparam int unsigned CntW = $clog2(DIV_NUM_W + 1);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // Bring down the next numerator bit and try a subtraction.
  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntW'(DIV_NUM_W);
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
    end else if (run_q) begin
      rem_d = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      num_d = {num_q[DIV_NUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> rtl/core/rws_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on rws_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module rws_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rws_pkg::ROOT_IN_W-1:0] val_i,
  output logic                          done_o,
  output logic [rws_pkg::ROOT_W-1:0]    root_o
);
  import rws_pkg::*;

  localparam int unsigned AccW = ROOT_IN_W + 1;

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [AccW-1:0] val_q, val_d;
  logic [AccW-1:0] res_q, res_d;
  logic [AccW-1:0] bit_q, bit_d;
  logic [AccW-1:0] trial;

  assign trial = res_q + bit_q;

  // Each step settles one result bit and moves the probe two places down.
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    val_d  = val_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      run_d = 1'b1;
      val_d = AccW'(val_i);
      res_d = '0;
      bit_d = AccW'(1) << (ROOT_IN_W - 1);
    end else if (run_q) begin
      if (val_q >= trial) begin
        val_d = val_q - trial;
        res_d = {1'b0, res_q[AccW-1:1]} + bit_q;
      end else begin
        res_d = {1'b0, res_q[AccW-1:1]};
      end
      bit_d = {2'b00, bit_q[AccW-1:2]};
      if (bit_q == AccW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/rws_checker.sv
// Port-level checks of the rolling window block, bound to its top level.
// Depends on rws_pkg, assert_macros.svh and the ports of rolling_window_statistics.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rws_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic signed [rws_pkg::STAT_W-1:0] stat_value_i,
  input logic                            window_full_i,
  input logic                            bad_config_i
);
  import rws_pkg::*;

  // A stalled result holds its value.
  `RWS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(stat_value_i))

  // Results of a filling window or a bad configuration are zero.
  `RWS_ASSERT(a_zero_result, clk_i, rst_ni, out_valid_i && (!window_full_i || bad_config_i) |-> stat_value_i == 0)

  // After a sample transaction the block is busy with it.
  `RWS_ASSERT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i)

  // A new result only appears at the end of work on an item.
  `RWS_ASSERT(a_result_from_work, clk_i, rst_ni, $rose(out_valid_i) |-> $past(!in_ready_i))

endmodule

bind rolling_window_statistics rws_checker u_rws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (smp_i.valid),
  .in_ready_i    (smp_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .stat_value_i  (res_o.stat_value),
  .window_full_i (res_o.window_full),
  .bad_config_i  (res_o.bad_config)
);

`default_nettype wire
